### hw/rtl/page_bitmap_allocator_core_defines.svh
// Assertion macros for the page bitmap allocator.
// Included by the top level; no other dependencies.
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pba assertion failed");
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pba assertion failed");
`else
`define PBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/pba_pkg.sv
// Shared constants, types and helpers of the page bitmap allocator.
// No dependencies.
package pba_pkg;

  localparam int unsigned MAX_PAGES  = 1024;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned NUM_WORDS  = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned IDX_W      = WADDR_W + BIT_W;
  localparam int unsigned CNT_W      = $clog2(MAX_PAGES + 1);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_VPAGE  = 2'd1;
  localparam logic [1:0] ST_PHYS_FAIL = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic REG_WINDOW_START = 1'b0;
  localparam logic REG_WINDOW_END   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_READ
  } state_t;

  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_word;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_word;
    logic [WORD_W-1:0]  wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  rd_data;
    logic               any_open;
    logic [WADDR_W-1:0] open_word;
  } mem_rsp_t;

  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

### hw/rtl/pba_bitmap.sv
// Used-page bitmap: word memory with per-word valid and full flags.
// Depends on pba_pkg.
module pba_bitmap (
  input  logic              clk,
  input  logic              rst_n,
  input  pba_pkg::mem_req_t req,
  output pba_pkg::mem_rsp_t rsp
);

  logic [pba_pkg::WORD_W-1:0]    mem [pba_pkg::NUM_WORDS];
  logic [pba_pkg::WORD_W-1:0]    rd_data_r;
  logic                          rd_valid_r;
  logic [pba_pkg::NUM_WORDS-1:0] valid_r;
  logic [pba_pkg::NUM_WORDS-1:0] full_r;
  logic                          any_open;
  logic [pba_pkg::WADDR_W-1:0]   open_word;

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_word] <= req.wr_data;
    if (req.rd_en) rd_data_r <= mem[req.rd_word];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      full_r     <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_word] <= 1'b1;
        full_r[req.wr_word]  <= &req.wr_data;
      end
      if (req.rd_en) rd_valid_r <= valid_r[req.rd_word];
    end
  end

  always_comb begin
    any_open  = 1'b0;
    open_word = '0;
    for (int i = pba_pkg::NUM_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        any_open  = 1'b1;
        open_word = pba_pkg::WADDR_W'(i);
      end
    end
  end

  assign rsp.rd_data   = rd_valid_r ? rd_data_r : '0;
  assign rsp.any_open  = any_open;
  assign rsp.open_word = open_word;

endmodule

### hw/rtl/pba_ctrl.sv
// Request sequencer: range check, first-fit search and bitmap update.
// Depends on pba_pkg.
module pba_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        in_kind,
  input  logic [pba_pkg::ADDR_W-1:0]  in_page_address,
  input  logic                        in_phys_ok,
  input  logic [pba_pkg::ADDR_W-1:0]  win_start,
  input  logic [pba_pkg::ADDR_W-1:0]  win_end,
  input  logic [pba_pkg::CNT_W-1:0]   page_count,
  input  pba_pkg::mem_rsp_t           rsp,
  output pba_pkg::mem_req_t           req,
  output logic                        busy,
  output logic                        out_valid,
  output logic [pba_pkg::ADDR_W-1:0]  out_granted_address,
  output logic [1:0]                  out_status
);

  pba_pkg::state_t              state_r, state_nxt;
  logic                         kind_r;
  logic [pba_pkg::ADDR_W-1:0]   addr_r;
  logic                         phys_r;
  logic [pba_pkg::WADDR_W-1:0]  word_r, word_nxt;
  logic [pba_pkg::BIT_W-1:0]    bit_r, bit_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [pba_pkg::ADDR_W-1:0]   gaddr_r, gaddr_nxt;
  logic [1:0]                   status_r, status_nxt;

  logic [pba_pkg::ADDR_W-1:0]   diff;
  logic [pba_pkg::ADDR_W-1:0]   free_idx;
  logic                         free_ok;
  logic [pba_pkg::BIT_W-1:0]    zero_bit;
  logic [pba_pkg::IDX_W-1:0]    alloc_idx;
  logic                         alloc_ok;
  logic [pba_pkg::WORD_W-1:0]   set_word;
  logic [pba_pkg::WORD_W-1:0]   clr_word;
  logic [pba_pkg::ADDR_W-1:0]   grant;

  assign diff     = addr_r - win_start;
  assign free_idx = diff >> pba_pkg::PAGE_SHIFT;
  assign free_ok  = (addr_r >= win_start) && (addr_r < win_end) &&
                    (free_idx < pba_pkg::ADDR_W'(page_count));

  assign zero_bit  = pba_pkg::first_zero(rsp.rd_data);
  assign alloc_idx = {word_r, zero_bit};
  assign alloc_ok  = pba_pkg::ADDR_W'(alloc_idx) < pba_pkg::ADDR_W'(page_count);
  assign set_word  = rsp.rd_data | (pba_pkg::WORD_W'(1) << zero_bit);
  assign clr_word  = rsp.rd_data & ~(pba_pkg::WORD_W'(1) << bit_r);
  assign grant     = win_start + (pba_pkg::ADDR_W'(alloc_idx) << pba_pkg::PAGE_SHIFT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pba_pkg::S_IDLE: if (start) state_nxt = pba_pkg::S_LOOK;
      pba_pkg::S_LOOK: begin
        if (kind_r == pba_pkg::KIND_FREE) begin
          state_nxt = free_ok ? pba_pkg::S_READ : pba_pkg::S_IDLE;
        end else begin
          state_nxt = rsp.any_open ? pba_pkg::S_READ : pba_pkg::S_IDLE;
        end
      end
      pba_pkg::S_READ: state_nxt = pba_pkg::S_IDLE;
      default:         state_nxt = pba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req           = '0;
    busy          = 1'b1;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    out_valid_nxt = 1'b0;
    gaddr_nxt     = '0;
    status_nxt    = pba_pkg::ST_OK;
    unique case (state_r)
      pba_pkg::S_IDLE: busy = 1'b0;
      pba_pkg::S_LOOK: begin
        if (kind_r == pba_pkg::KIND_FREE) begin
          word_nxt    = free_idx[pba_pkg::IDX_W-1:pba_pkg::BIT_W];
          bit_nxt     = free_idx[pba_pkg::BIT_W-1:0];
          req.rd_en   = free_ok;
          req.rd_word = free_idx[pba_pkg::IDX_W-1:pba_pkg::BIT_W];
          if (!free_ok) begin
            out_valid_nxt = 1'b1;
            status_nxt    = pba_pkg::ST_RANGE;
          end
        end else begin
          word_nxt    = rsp.open_word;
          req.rd_en   = rsp.any_open;
          req.rd_word = rsp.open_word;
          if (!rsp.any_open) begin
            out_valid_nxt = 1'b1;
            status_nxt    = pba_pkg::ST_NO_VPAGE;
          end
        end
      end
      pba_pkg::S_READ: begin
        out_valid_nxt = 1'b1;
        req.wr_word   = word_r;
        if (kind_r == pba_pkg::KIND_FREE) begin
          req.wr_en   = 1'b1;
          req.wr_data = clr_word;
        end else if (!alloc_ok) begin
          status_nxt = pba_pkg::ST_NO_VPAGE;
        end else if (!phys_r) begin
          status_nxt = pba_pkg::ST_PHYS_FAIL;
        end else begin
          req.wr_en   = 1'b1;
          req.wr_data = set_word;
          gaddr_nxt   = grant;
        end
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pba_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pba_pkg::S_IDLE && start) begin
      kind_r <= in_kind;
      addr_r <= in_page_address;
      phys_r <= in_phys_ok;
    end
    word_r   <= word_nxt;
    bit_r    <= bit_nxt;
    gaddr_r  <= gaddr_nxt;
    status_r <= status_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = gaddr_r;
  assign out_status          = status_r;

endmodule

### hw/rtl/page_bitmap_allocator_core.sv
// Top level of the first-fit page bitmap allocator.
// Depends on pba_pkg, pba_ctrl, pba_bitmap and the defines header.
//
// Usage:
//   Requests enter on start while busy is low, with in_kind (0 allocate,
//   1 free), in_page_address (free only) and in_phys_ok (allocate only).
//   Each request yields one result: out_valid is high for one cycle with
//   out_granted_address and out_status (0 ok, 1 no free page, 2 physical
//   failure, 3 free out of range). The receiver takes every result as it
//   appears; there is no stall path. The window registers are written
//   through cfg_we / cfg_index / cfg_wdata, by the user only while no
//   request is in flight; the block itself does not enforce this.
// Timing:
//   out_valid is registered from the check state for a request that
//   ends there (free out of range, every bitmap word full), else from
//   the read state that follows it, where the bitmap word read returns
//   and is written back. busy drops as the result appears, so a new
//   request is taken only after the previous one has ended.
// Reset:
//   Synchronous on rst_n: window registers to zero, all pages free via
//   per-word valid flags; no clearing pass is needed.
`include "page_bitmap_allocator_core_defines.svh"

module page_bitmap_allocator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [pba_pkg::ADDR_W-1:0]  in_page_address,
  input  logic                        in_phys_ok,
  output logic                        out_valid,
  output logic [pba_pkg::ADDR_W-1:0]  out_granted_address,
  output logic [1:0]                  out_status,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pba_pkg::ADDR_W-1:0]  cfg_wdata
);

  logic [pba_pkg::ADDR_W-1:0] win_start_r;
  logic [pba_pkg::ADDR_W-1:0] win_end_r;
  logic [pba_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [pba_pkg::ADDR_W-1:0] span_pages;
  pba_pkg::mem_req_t          req;
  pba_pkg::mem_rsp_t          rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_end_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pba_pkg::REG_WINDOW_START: win_start_r <= cfg_wdata;
        pba_pkg::REG_WINDOW_END:   win_end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign span_pages = (win_end_r - win_start_r) >> pba_pkg::PAGE_SHIFT;

  always_comb begin
    priority if (win_end_r <= win_start_r) begin
      count_nxt = '0;
    end else if (span_pages > pba_pkg::ADDR_W'(pba_pkg::MAX_PAGES)) begin
      count_nxt = pba_pkg::CNT_W'(pba_pkg::MAX_PAGES);
    end else begin
      count_nxt = span_pages[pba_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  pba_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .in_kind             (in_kind),
    .in_page_address     (in_page_address),
    .in_phys_ok          (in_phys_ok),
    .win_start           (win_start_r),
    .win_end             (win_end_r),
    .page_count          (count_r),
    .rsp                 (rsp),
    .req                 (req),
    .busy                (busy),
    .out_valid           (out_valid),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

  pba_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  `PBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `PBA_ASSERT_SAME(a_result_idle, clk, rst_n, out_valid, !busy && $past(busy))
  `PBA_ASSERT_SAME(a_fail_no_addr, clk, rst_n, out_valid && out_status != pba_pkg::ST_OK, out_granted_address == '0)
  `PBA_ASSERT_SAME(a_single_access, clk, rst_n, req.wr_en, !req.rd_en)

endmodule
